### rtl/assert_macros.svh
// assertion helpers; expect clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/vfd_pkg.sv
`timescale 1ns / 1ps
package vfd_pkg;
	localparam int MAX_DEPTH = 32768;
	localparam int ADDR_W = 15;
	localparam int LEN_W = ADDR_W + 1;
	localparam int SAMPLE_W = 24;
	localparam int RATE_W = 19;
	localparam int POS_W = 31;
	localparam int CFG_W = 17;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SLEW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLLISION_ZONE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_SCALE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WET_MIX = 3'd6;

	localparam logic [15:0] RST_BUFFER_LENGTH = 16'd21845;
	localparam logic [16:0] RST_RATE_SLEW = 17'd33;
	localparam logic [10:0] RST_DEAD_ZONE = 11'd5;
	localparam logic [12:0] RST_COLLISION_ZONE = 13'd100;
	localparam logic [16:0] RST_RAMP_SCALE = 17'd690;
	localparam logic [15:0] RST_FEEDBACK_GAIN = 16'd26214;
	localparam logic [15:0] RST_WET_MIX = 16'd32768;
	localparam logic [POS_W-1:0] RST_POSITION = 31'd715816960;
	localparam logic signed [RATE_W-1:0] RST_RATE = 19'sd65536;
	localparam logic [16:0] UNITY_Q16 = 17'd65536;
	localparam logic [15:0] UNITY_Q15 = 16'd32768;

	typedef enum logic [1:0] {MUL_INTERP, MUL_VOL, MUL_FB, MUL_MIX} mul_op_t;
	typedef enum logic [1:0] {VOL_ZERO, VOL_RAMP, VOL_ONE} vol_sel_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_SLEW, ST_ADV, ST_WRAP, ST_MOD, ST_DIST, ST_RDHI,
		ST_RAMP, ST_VOL, ST_INTERP, ST_RL, ST_VOLM, ST_RV, ST_FBM, ST_STORE,
		ST_MIXM, ST_OUT
	} vfd_state_t;

	typedef struct packed {
		logic accept;
		logic slew;
		logic advance;
		logic wrap;
		logic mod_step;
		logic locate;
		logic rd_hi;
		logic ramp;
		logic vol;
		logic mul_en;
		mul_op_t mul_op;
		logic take_interp;
		logic take_vol;
		logic store;
		logic out_load;
		logic clear;
	} vfd_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic wrap_mod;
		logic mod_last;
	} vfd_status_t;

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [31:0] v);
		logic signed [31:0] hi;
		logic signed [31:0] lo;
		hi = 32'sd8388607;
		lo = -32'sd8388608;
		if (v > hi)
			sat_sample = hi[SAMPLE_W-1:0];
		else if (v < lo)
			sat_sample = lo[SAMPLE_W-1:0];
		else
			sat_sample = v[SAMPLE_W-1:0];
	endfunction
endpackage

### rtl/vfd_lane.sv
`timescale 1ns / 1ps
module vfd_lane import vfd_pkg::*; (
	input logic clk,
	input vfd_cmd_t cmd,
	input logic signed [SAMPLE_W-1:0] x,
	input logic [15:0] frac,
	input logic [16:0] vol,
	input logic [15:0] fb,
	input logic [15:0] wet,
	input logic [ADDR_W-1:0] rd_addr,
	input logic [ADDR_W-1:0] wr_addr,
	output logic signed [SAMPLE_W-1:0] y
);
	logic signed [SAMPLE_W-1:0] mem [MAX_DEPTH];
	logic signed [SAMPLE_W-1:0] dout_q;
	logic signed [SAMPLE_W-1:0] lo_q;
	logic signed [24:0] r_q;
	logic signed [43:0] prod_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic signed [25:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [45:0] s_interp;
	logic signed [45:0] s_vol;
	logic signed [45:0] s_fb;
	logic signed [45:0] s_mix;
	logic signed [30:0] fb_t;
	logic signed [30:0] mix_t;
	logic signed [SAMPLE_W-1:0] wdata;
	logic we;
	logic rd_en;

	always_comb begin
		case (cmd.mul_op)
			MUL_INTERP: begin
				mul_a = 26'(dout_q) - 26'(lo_q);
				mul_b = {2'b00, frac};
			end
			MUL_VOL: begin
				mul_a = 26'(r_q);
				mul_b = {1'b0, vol};
			end
			MUL_FB: begin
				mul_a = 26'(r_q);
				mul_b = {2'b00, fb};
			end
			MUL_MIX: begin
				mul_a = 26'(r_q) - 26'(x);
				mul_b = {2'b00, wet};
			end
			default: begin
				mul_a = 26'(r_q);
				mul_b = {2'b00, fb};
			end
		endcase
	end

	// lo*(1-f) + hi*f folded to lo + (hi-lo)*f; dry/wet folded the same way
	assign s_interp = (46'(lo_q) <<< 16) + 46'(prod_q) + 46'sd32768;
	assign s_vol = 46'(prod_q) + 46'sd32768;
	assign s_fb = 46'(prod_q) + 46'sd16384;
	assign s_mix = (46'(x) <<< 15) + 46'(prod_q) + 46'sd16384;
	assign fb_t = s_fb[45:15];
	assign mix_t = s_mix[45:15];

	assign we = cmd.clear | cmd.store;
	assign rd_en = cmd.locate | cmd.rd_hi;
	assign wdata = cmd.clear ? '0 : sat_sample(32'(fb_t) + 32'(x));

	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wdata;
		if (rd_en)
			dout_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_hi)
			lo_q <= dout_q;
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		if (cmd.take_interp)
			r_q <= s_interp[40:16];
		else if (cmd.take_vol)
			r_q <= s_vol[40:16];
		if (cmd.out_load)
			y_q <= sat_sample(32'(mix_t));
	end

	assign y = y_q;
endmodule

### rtl/vfd_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vfd_datapath import vfd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic signed [SAMPLE_W-1:0] left_in,
	input logic signed [SAMPLE_W-1:0] right_in,
	input logic signed [RATE_W-1:0] target_rate,
	input vfd_cmd_t cmd,
	output vfd_status_t status,
	output logic signed [SAMPLE_W-1:0] left_out,
	output logic signed [SAMPLE_W-1:0] right_out
);
	logic [15:0] cfg_len_q;
	logic [16:0] cfg_slew_q;
	logic [10:0] cfg_dead_q;
	logic [12:0] cfg_coll_q;
	logic [16:0] cfg_ramp_q;
	logic [15:0] cfg_fb_q;
	logic [15:0] cfg_wet_q;

	logic [ADDR_W-1:0] wp_q;
	logic [POS_W-1:0] pos_q;
	logic signed [RATE_W-1:0] rate_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic signed [SAMPLE_W-1:0] xl_q;
	logic signed [SAMPLE_W-1:0] xr_q;
	logic signed [RATE_W-1:0] tgt_q;
	logic [ADDR_W-1:0] w_q;
	logic signed [32:0] p_q;
	logic [3:0] k_q;
	logic [31:0] d_q;
	vol_sel_t vsel_q;
	logic [31:0] rdist_q;
	logic [48:0] rprod_q;
	logic [16:0] vol_q;

	logic [LEN_W-1:0] len;
	logic [31:0] span;
	logic signed [32:0] span33;
	logic signed [32:0] p_up1;
	logic signed [32:0] p_up2;
	logic signed [20:0] diff;
	logic signed [20:0] slew21;
	logic signed [20:0] rate_next;
	logic [47:0] mod_cmp;
	logic signed [33:0] dv;
	logic signed [33:0] d34;
	logic signed [33:0] dead34;
	logic signed [33:0] coll34;
	logic signed [33:0] span34;
	logic [LEN_W-1:0] hi16;
	logic [ADDR_W-1:0] hi_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic [LEN_W-1:0] wn;
	logic [32:0] ramp_v;
	logic [15:0] fb_gain;
	logic [15:0] wet_lim;

	always_comb begin
		if (cfg_len_q < 16'd2)
			len = 16'd2;
		else if (cfg_len_q > 16'(MAX_DEPTH))
			len = 16'(MAX_DEPTH);
		else
			len = cfg_len_q;
	end

	assign span = {len, 16'h0000};
	assign span33 = {1'b0, span};
	// short buffers may need two spans to lift a negative head
	assign p_up1 = p_q + span33;
	assign p_up2 = p_up1 + span33;
	assign diff = 21'(tgt_q) - 21'(rate_q);
	assign slew21 = {4'b0000, cfg_slew_q};

	always_comb begin
		if (diff > slew21)
			rate_next = 21'(rate_q) + slew21;
		else if (diff < -slew21)
			rate_next = 21'(rate_q) - slew21;
		else
			rate_next = 21'(tgt_q);
	end

	assign mod_cmp = 48'(span) << k_q;
	assign dv = 34'(p_q) - $signed({3'b000, w_q, 16'h0000});
	assign d34 = {2'b00, d_q};
	assign dead34 = {7'd0, cfg_dead_q, 16'h0000};
	assign coll34 = {5'd0, cfg_coll_q, 16'h0000};
	assign span34 = {2'b00, span};
	assign hi16 = {1'b0, pos_q[POS_W-1:16]} + 16'd1;
	assign hi_addr = (hi16 >= len) ? '0 : hi16[ADDR_W-1:0];
	assign rd_addr = cmd.locate ? p_q[POS_W-1:16] : hi_addr;
	assign wr_addr = cmd.clear ? clr_cnt_q : w_q;
	assign wn = {1'b0, w_q} + 16'd1;
	assign ramp_v = rprod_q[48:16];
	assign fb_gain = (cfg_fb_q > UNITY_Q15) ? UNITY_Q15 : cfg_fb_q;
	assign wet_lim = (cfg_wet_q > UNITY_Q15) ? UNITY_Q15 : cfg_wet_q;

	assign status.clear_done = &clr_cnt_q;
	assign status.wrap_mod = !p_q[32] && (p_q >= span33);
	assign status.mod_last = (k_q == 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_len_q <= RST_BUFFER_LENGTH;
			cfg_slew_q <= RST_RATE_SLEW;
			cfg_dead_q <= RST_DEAD_ZONE;
			cfg_coll_q <= RST_COLLISION_ZONE;
			cfg_ramp_q <= RST_RAMP_SCALE;
			cfg_fb_q <= RST_FEEDBACK_GAIN;
			cfg_wet_q <= RST_WET_MIX;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BUFFER_LENGTH: cfg_len_q <= cfg_data[15:0];
				REG_RATE_SLEW: cfg_slew_q <= cfg_data;
				REG_DEAD_ZONE: cfg_dead_q <= cfg_data[10:0];
				REG_COLLISION_ZONE: cfg_coll_q <= cfg_data[12:0];
				REG_RAMP_SCALE: cfg_ramp_q <= cfg_data;
				REG_FEEDBACK_GAIN: cfg_fb_q <= cfg_data[15:0];
				REG_WET_MIX: cfg_wet_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			pos_q <= RST_POSITION;
			rate_q <= RST_RATE;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clear)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.slew)
				rate_q <= rate_next[RATE_W-1:0];
			if (cmd.locate)
				pos_q <= p_q[POS_W-1:0];
			if (cmd.store)
				wp_q <= (wn >= len) ? '0 : wn[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			xl_q <= left_in;
			xr_q <= right_in;
			tgt_q <= target_rate;
			w_q <= ({1'b0, wp_q} >= len) ? '0 : wp_q;
		end
		if (cmd.advance)
			p_q <= $signed({2'b00, pos_q}) + 33'(rate_q);
		else if (cmd.wrap) begin
			if (p_q[32])
				p_q <= p_up1[32] ? p_up2 : p_up1;
			k_q <= 4'd15;
		end else if (cmd.mod_step) begin
			if (48'(p_q) >= mod_cmp)
				p_q <= p_q - $signed(mod_cmp[32:0]);
			k_q <= k_q - 4'd1;
		end
		if (cmd.locate)
			d_q <= dv[33] ? 32'(-dv) : dv[31:0];
		if (cmd.rd_hi) begin
			rdist_q <= '0;
			if (d34 < dead34)
				vsel_q <= VOL_ZERO;
			else if (d34 < coll34) begin
				vsel_q <= VOL_RAMP;
				rdist_q <= 32'(d34 - dead34);
			end else if (d34 > span34 - dead34)
				vsel_q <= VOL_ZERO;
			else if (d34 > span34 - coll34) begin
				vsel_q <= VOL_RAMP;
				rdist_q <= 32'(span34 - d34 - dead34);
			end else
				vsel_q <= VOL_ONE;
		end
		if (cmd.ramp)
			rprod_q <= rdist_q * cfg_ramp_q;
		if (cmd.vol) begin
			case (vsel_q)
				VOL_ONE: vol_q <= UNITY_Q16;
				VOL_RAMP: vol_q <= (ramp_v > 33'(UNITY_Q16)) ? UNITY_Q16 : ramp_v[16:0];
				default: vol_q <= '0;
			endcase
		end
	end

	vfd_lane u_left (
		.clk(clk),
		.cmd(cmd),
		.x(xl_q),
		.frac(pos_q[15:0]),
		.vol(vol_q),
		.fb(fb_gain),
		.wet(wet_lim),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.y(left_out)
	);

	vfd_lane u_right (
		.clk(clk),
		.cmd(cmd),
		.x(xr_q),
		.frac(pos_q[15:0]),
		.vol(vol_q),
		.fb(fb_gain),
		.wet(wet_lim),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.y(right_out)
	);

	`ASSERT_CLK(a_pos_in_span, cmd.locate |-> (!p_q[32] && (p_q < span33)), "read head outside buffer")
	`ASSERT_CLK(a_vol_capped, cmd.vol |=> (vol_q <= UNITY_Q16), "volume above unity")
endmodule

### rtl/vfd_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vfd_ctrl import vfd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	input vfd_status_t status,
	output vfd_cmd_t cmd
);
	vfd_state_t state_q;
	vfd_state_t state_d;
	logic out_valid_q;
	logic slot_free;

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (status.clear_done) state_d = ST_IDLE;
			ST_IDLE: if (in_valid) state_d = ST_SLEW;
			ST_SLEW: state_d = ST_ADV;
			ST_ADV: state_d = ST_WRAP;
			ST_WRAP: state_d = status.wrap_mod ? ST_MOD : ST_DIST;
			ST_MOD: if (status.mod_last) state_d = ST_DIST;
			ST_DIST: state_d = ST_RDHI;
			ST_RDHI: state_d = ST_RAMP;
			ST_RAMP: state_d = ST_VOL;
			ST_VOL: state_d = ST_INTERP;
			ST_INTERP: state_d = ST_RL;
			ST_RL: state_d = ST_VOLM;
			ST_VOLM: state_d = ST_RV;
			ST_RV: state_d = ST_FBM;
			ST_FBM: state_d = ST_STORE;
			ST_STORE: state_d = ST_MIXM;
			ST_MIXM: state_d = ST_OUT;
			ST_OUT: if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_IDLE: cmd.accept = in_valid;
			ST_SLEW: cmd.slew = 1'b1;
			ST_ADV: cmd.advance = 1'b1;
			ST_WRAP: cmd.wrap = 1'b1;
			ST_MOD: cmd.mod_step = 1'b1;
			ST_DIST: cmd.locate = 1'b1;
			ST_RDHI: cmd.rd_hi = 1'b1;
			ST_RAMP: cmd.ramp = 1'b1;
			ST_VOL: cmd.vol = 1'b1;
			ST_INTERP: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_INTERP;
			end
			ST_RL: cmd.take_interp = 1'b1;
			ST_VOLM: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_VOL;
			end
			ST_RV: cmd.take_vol = 1'b1;
			ST_FBM: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_FB;
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				cmd.mul_op = MUL_FB;
			end
			ST_MIXM: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MUL_MIX;
			end
			ST_OUT: cmd.out_load = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	`ASSERT_ALWAYS(a_stall_while_clearing, (state_q == ST_CLEAR) |-> in_stall, "item taken during clear")
	`ASSERT_CLK(a_one_item_in_flight, (in_valid && !in_stall) |=> in_stall, "second item taken while busy")
endmodule

### rtl/varispeed_feedback_delay_core.sv
`timescale 1ns / 1ps
// Stereo variable-speed delay with feedback.
// Input channel: in_valid/in_stall carry left_in, right_in (Q1.23) and
// target_rate (Q16, signed). Output channel: out_valid/out_stall carry
// left_out, right_out (Q1.23, saturated), one output item per input item.
// When the advanced read head reaches or passes the end of the active
// length (a forward wrap, or a stale head after a shortening write to
// buffer_length) a modulo reduction step runs, one bit per cycle.
// The sequencer handles one item at a time and takes no new item until the
// last one has left its final step; each channel has a single shared
// multiplier, and the sample memories are read and written in separate steps.
// The result sits in an output register: the next item is accepted while
// a stalled result waits, and the block then holds in its last step until
// the output register frees up.
// After reset both 32768-entry sample memories are zeroed, one entry per
// cycle; in_stall stays high meanwhile. Configuration writes (cfg_we,
// cfg_index, cfg_data) are accepted at any time, but must only be issued
// while the block is idle.
module varispeed_feedback_delay_core import vfd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [SAMPLE_W-1:0] left_in,
	input logic signed [SAMPLE_W-1:0] right_in,
	input logic signed [RATE_W-1:0] target_rate,
	output logic out_valid,
	input logic out_stall,
	output logic signed [SAMPLE_W-1:0] left_out,
	output logic signed [SAMPLE_W-1:0] right_out
);
	vfd_cmd_t cmd;
	vfd_status_t status;

	vfd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.cmd(cmd)
	);

	vfd_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.left_in(left_in),
		.right_in(right_in),
		.target_rate(target_rate),
		.cmd(cmd),
		.status(status),
		.left_out(left_out),
		.right_out(right_out)
	);
endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import vfd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 220;

	typedef struct {
		logic signed [SAMPLE_W-1:0] l;
		logic signed [SAMPLE_W-1:0] r;
	} stereo_t;

	typedef struct {
		bit is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0] val;
		logic signed [SAMPLE_W-1:0] l;
		logic signed [SAMPLE_W-1:0] r;
		logic signed [RATE_W-1:0] t;
		bit fixed;
		logic signed [SAMPLE_W-1:0] el;
		logic signed [SAMPLE_W-1:0] er;
	} vector_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [SAMPLE_W-1:0] left_in;
	logic signed [SAMPLE_W-1:0] right_in;
	logic signed [RATE_W-1:0] target_rate;
	logic out_valid;
	logic out_stall;
	logic signed [SAMPLE_W-1:0] left_out;
	logic signed [SAMPLE_W-1:0] right_out;

	varispeed_feedback_delay_core uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
		.left_in(left_in), .right_in(right_in), .target_rate(target_rate),
		.out_valid(out_valid), .out_stall(out_stall), .left_out(left_out),
		.right_out(right_out)
	);

	// shadow of the registers and the delay line
	int reg_shadow[7];
	int reg_width[7] = '{16, 17, 11, 13, 17, 16, 16};
	longint mem_left[MAX_DEPTH];
	longint mem_right[MAX_DEPTH];
	longint wr_ptr;
	longint pos_q16;
	longint rate_q16;

	stereo_t pending_out[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	int stall_run = 0;

	function automatic longint round_sh(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clip(longint v);
		if (v > 8388607)
			return 8388607;
		if (v < -8388608)
			return -8388608;
		return v;
	endfunction

	function automatic longint ramp_vol(longint ofs);
		longint v;
		v = (ofs * reg_shadow[REG_RAMP_SCALE]) >>> 16;
		return v > 65536 ? 65536 : v;
	endfunction

	function automatic stereo_t delay_step(longint xl, longint xr, longint target);
		longint len, span, slew, diff, w, d, dead, coll, vol, lo, hi, frac;
		longint rl, rr, fb, wet, dry;
		stereo_t o;
		len = reg_shadow[REG_BUFFER_LENGTH];
		if (len < 2)
			len = 2;
		if (len > MAX_DEPTH)
			len = MAX_DEPTH;
		span = len <<< 16;
		slew = reg_shadow[REG_RATE_SLEW];
		w = wr_ptr;
		if (w >= len)
			w = 0;
		diff = target - rate_q16;
		if (diff > slew)
			rate_q16 += slew;
		else if (diff < -slew)
			rate_q16 -= slew;
		else
			rate_q16 = target;
		pos_q16 = (pos_q16 + rate_q16) % span;
		if (pos_q16 < 0)
			pos_q16 += span;
		d = pos_q16 - (w <<< 16);
		if (d < 0)
			d = -d;
		dead = longint'(reg_shadow[REG_DEAD_ZONE]) <<< 16;
		coll = longint'(reg_shadow[REG_COLLISION_ZONE]) <<< 16;
		if (d < dead)
			vol = 0;
		else if (d < coll)
			vol = ramp_vol(d - dead);
		else if (d > span - dead)
			vol = 0;
		else if (d > span - coll)
			vol = ramp_vol(span - d - dead);
		else
			vol = 65536;
		lo = pos_q16 >>> 16;
		hi = lo + 1;
		if (hi >= len)
			hi = 0;
		frac = pos_q16 & 64'hFFFF;
		rl = round_sh(mem_left[lo] * (65536 - frac) + mem_left[hi] * frac, 16);
		rr = round_sh(mem_right[lo] * (65536 - frac) + mem_right[hi] * frac, 16);
		rl = round_sh(rl * vol, 16);
		rr = round_sh(rr * vol, 16);
		fb = reg_shadow[REG_FEEDBACK_GAIN] > 32768 ? 32768 : reg_shadow[REG_FEEDBACK_GAIN];
		mem_left[w] = clip(round_sh(rl * fb, 15) + xl);
		mem_right[w] = clip(round_sh(rr * fb, 15) + xr);
		w++;
		if (w >= len)
			w = 0;
		wr_ptr = w;
		wet = reg_shadow[REG_WET_MIX] > 32768 ? 32768 : reg_shadow[REG_WET_MIX];
		dry = 32768 - wet;
		o.l = SAMPLE_W'(clip(round_sh(xl * dry + rl * wet, 15)));
		o.r = SAMPLE_W'(clip(round_sh(xr * dry + rr * wet, 15)));
		return o;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (quiet || p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin : out_check
		stereo_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_out.size() == 0) begin
				$error("item with no expectation: left_out %0d right_out %0d", left_out,
					right_out);
				errors++;
			end else begin
				e = pending_out.pop_front();
				if (left_out !== e.l) begin
					$error("left_out expected %0d actual %0d", e.l, left_out);
					errors++;
				end
				if (right_out !== e.r) begin
					$error("right_out expected %0d actual %0d", e.r, right_out);
					errors++;
				end
			end
		end
		if (stall_run > 0)
			stall_run--;
		else if (!quiet && $urandom_range(0, 99) < 20)
			stall_run = gap_len();
		out_stall <= (stall_run > 0);
	end

	task automatic wait_idle();
		while (pending_out.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < 7)
			reg_shadow[idx] = val & ((1 << reg_width[idx]) - 1);
		@(posedge clk);
	endtask

	task automatic send_item(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
			logic signed [RATE_W-1:0] t, bit fixed, stereo_t typed);
		stereo_t o;
		int g;
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		target_rate <= t;
		do
			@(posedge clk);
		while (in_stall);
		o = delay_step(l, r, t);
		pending_out.push_back(fixed ? typed : o);
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		int p;
		p = $urandom_range(0, 19);
		if (p == 0)
			return 24'sh7FFFFF;
		if (p == 1)
			return 24'sh800000;
		return SAMPLE_W'($urandom());
	endfunction

	function automatic logic signed [RATE_W-1:0] rand_rate();
		int p;
		p = $urandom_range(0, 9);
		if (p < 5)
			return RATE_W'($urandom_range(0, 262144) - 131072);
		if (p < 8)
			return RATE_W'($urandom_range(0, 4096) + (($urandom_range(0, 1)) ? 63488 : -67584));
		return RATE_W'($urandom());
	endfunction

	function automatic logic [CFG_W-1:0] pick(int lo, int hi, int dflt, int p);
		case (p)
			0: return CFG_W'(lo);
			1: return CFG_W'(hi);
			2: return CFG_W'(dflt);
			default: return CFG_W'($urandom_range(lo, hi));
		endcase
	endfunction

	vector_t directed[] = '{
		'{0, 0, 0, 24'sh7FFFFF, 24'sh800000, 19'sd131072, 1, 0, 0},
		'{0, 0, 0, 24'sh800000, 24'sh7FFFFF, -19'sd131072, 1, 0, 0},
		'{0, 0, 0, 24'sh000000, 24'shFFFFFF, 19'sh40000, 1, 0, 0},
		'{0, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 19'sh3FFFF, 1, 0, 0},
		'{0, 0, 0, 24'sh555555, 24'shAAAAAA, 19'sd0, 1, 0, 0},
		'{1, REG_BUFFER_LENGTH, 17'd0, 0, 0, 0, 0, 0, 0},
		'{1, REG_RATE_SLEW, 17'd131071, 0, 0, 0, 0, 0, 0},
		'{1, REG_UNUSED, 17'h1FFFF, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 24'sh7FFFFF, 24'sh800000, 19'sd65536, 0, 0, 0},
		'{0, 0, 0, 24'sh7FFFFF, 24'sh800000, -19'sd32768, 0, 0, 0},
		'{0, 0, 0, 24'sh123456, 24'shEDCBA9, 19'sd98304, 0, 0, 0},
		'{0, 0, 0, 24'sh800000, 24'sh7FFFFF, -19'sd131072, 0, 0, 0},
		'{1, REG_FEEDBACK_GAIN, 17'd65535, 0, 0, 0, 0, 0, 0},
		'{1, REG_WET_MIX, 17'd0, 0, 0, 0, 0, 0, 0},
		'{1, REG_BUFFER_LENGTH, 17'd65535, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 19'sh3FFFF, 1, 24'sh7FFFFF, 24'sh7FFFFF},
		'{0, 0, 0, 24'sh800000, 24'sh800000, 19'sh40000, 1, 24'sh800000, 24'sh800000},
		'{1, REG_WET_MIX, 17'd16384, 0, 0, 0, 0, 0, 0},
		'{1, REG_DEAD_ZONE, 17'd0, 0, 0, 0, 0, 0, 0},
		'{1, REG_COLLISION_ZONE, 17'd8191, 0, 0, 0, 0, 0, 0},
		'{1, REG_RAMP_SCALE, 17'd131071, 0, 0, 0, 0, 0, 0},
		'{1, REG_BUFFER_LENGTH, 17'd3, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 24'sh400000, 24'shC00000, 19'sd65536, 0, 0, 0},
		'{0, 0, 0, 24'sh3FFFFF, 24'shC00001, 19'sd40000, 0, 0, 0},
		'{0, 0, 0, 24'sh000001, 24'shFFFFFF, -19'sd70000, 0, 0, 0}
	};

	initial begin
		stereo_t typed;
		int len_pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		left_in = '0;
		right_in = '0;
		target_rate = '0;
		out_stall = 1'b0;
		reg_shadow = '{RST_BUFFER_LENGTH, RST_RATE_SLEW, RST_DEAD_ZONE, RST_COLLISION_ZONE,
			RST_RAMP_SCALE, RST_FEEDBACK_GAIN, RST_WET_MIX};
		foreach (mem_left[i]) begin
			mem_left[i] = 0;
			mem_right[i] = 0;
		end
		wr_ptr = 0;
		pos_q16 = longint'(RST_BUFFER_LENGTH) <<< 15;
		rate_q16 = 65536;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].is_cfg) begin
				in_valid <= 1'b0;
				wait_idle();
				write_reg(directed[i].idx, directed[i].val);
			end else begin
				typed.l = directed[i].el;
				typed.r = directed[i].er;
				send_item(directed[i].l, directed[i].r, directed[i].t, directed[i].fixed,
					typed);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			in_valid <= 1'b0;
			wait_idle();
			quiet = (ph % 4 == 3);
			len_pick = $urandom_range(0, 9);
			case (len_pick)
				0, 1, 2: write_reg(REG_BUFFER_LENGTH, CFG_W'($urandom_range(2, 64)));
				3: write_reg(REG_BUFFER_LENGTH, CFG_W'($urandom_range(0, 3)));
				4, 5: write_reg(REG_BUFFER_LENGTH, CFG_W'($urandom_range(100, 2000)));
				6: write_reg(REG_BUFFER_LENGTH, 17'd32768);
				7: write_reg(REG_BUFFER_LENGTH, 17'd65535);
				default: write_reg(REG_BUFFER_LENGTH, CFG_W'($urandom_range(0, 65535)));
			endcase
			write_reg(REG_RATE_SLEW, pick(0, 131071, 33, $urandom_range(0, 4)));
			write_reg(REG_DEAD_ZONE, CFG_W'(pick(0, 2047, 5, $urandom_range(0, 4)) %
				($urandom_range(0, 1) ? 2048 : 16)));
			write_reg(REG_COLLISION_ZONE, CFG_W'(pick(0, 8191, 100, $urandom_range(0, 4)) %
				($urandom_range(0, 1) ? 8192 : 64)));
			write_reg(REG_RAMP_SCALE, pick(0, 131071, 690, $urandom_range(0, 4)));
			write_reg(REG_FEEDBACK_GAIN, pick(0, 65535, 32768, $urandom_range(0, 4)));
			write_reg(REG_WET_MIX, pick(0, 65535, 32768, $urandom_range(0, 4)));
			for (int k = 0; k < PHASE_ITEMS; k++)
				send_item(rand_sample(), rand_sample(), rand_rate(), 0, typed);
		end

		in_valid <= 1'b0;
		wait_idle();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule

### varispeed_feedback_delay_core.f
+incdir+rtl
rtl/vfd_pkg.sv
rtl/vfd_lane.sv
rtl/vfd_datapath.sv
rtl/vfd_ctrl.sv
rtl/varispeed_feedback_delay_core.sv
bench/testbench.sv
